// File: design/rpg_pkg.sv
// Package for the random permutation generator.
// Holds the shared widths, generator constants and the command and status
// structs that join the controller to the datapath. Depends on nothing.
package rpg_pkg;

	// Store geometry and counter widths.
	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int SEED_W       = 32;
	localparam int GEN_W        = 48;
	localparam int HALF_W       = GEN_W / 2;
	localparam int DRAW_W       = 32;
	localparam int MOD_CNT_W    = 4;

	// Linear congruential generator constants, multiplier split in halves.
	localparam logic [HALF_W-1:0] LCG_MUL_LO = 24'hECE66D;
	localparam logic [HALF_W-1:0] LCG_MUL_HI = 24'h0005DE;
	localparam logic [GEN_W-1:0]  LCG_ADD    = 48'h0000_0000_000B;
	localparam logic [15:0]       LCG_LOW    = 16'h330E;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_n;     // latch the saturated count, clear the index
		logic fill_we;    // write the identity entry and advance the index
		logic load_i;     // start the shuffle index at count minus one
		logic mul0;       // low by low partial product plus increment
		logic mul1;       // low by high cross product
		logic mul2;       // high by low cross product, commit the new state
		logic mod_step;   // two remainder bits of the draw
		logic rd_i;       // read entry i
		logic rd_pick;    // read the picked entry, keep entry i
		logic wr_i;       // write the picked value into entry i
		logic wr_pick;    // write the kept value into the picked entry
		logic clr_idx;    // clear the index before emission
		logic rd_k;       // read the entry at the index
		logic load_out;   // load the output register
		logic inc_idx;    // advance the index
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;   // index equals count minus one
		logic i_gt1;      // shuffle index above one
		logic mod_done;   // final remainder step in this cycle
	} sts_t;

endpackage

// File: design/rpg_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for the permutation store. Depends on nothing.
module rpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/rpg_datapath.sv
// Datapath of the random permutation generator: generator state, shared
// partial product multiplier, remainder unit, counters and store access.
// Depends on rpg_pkg and rpg_ram.
module rpg_datapath
	import rpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [CNT_W-1:0]  count,
	input  logic              seed_we,
	input  logic [SEED_W-1:0] seed,
	output logic [ADDR_W-1:0] out_value,
	output logic              out_last
);

	logic [GEN_W-1:0]     gen_q;
	logic [GEN_W-1:0]     acc_q;
	logic [GEN_W-1:0]     gen_next;
	logic [HALF_W-1:0]    mul_a;
	logic [HALF_W-1:0]    mul_b;
	logic [GEN_W-1:0]     mul_p;
	logic [DRAW_W-1:0]    draw_q;
	logic [ADDR_W-1:0]    rem_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [ADDR_W:0]      t1;
	logic [ADDR_W:0]      t2;
	logic [ADDR_W:0]      div;
	logic [ADDR_W-1:0]    r1;
	logic [ADDR_W-1:0]    r2;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     idx_q;
	logic [ADDR_W-1:0]    i_q;
	logic [ADDR_W-1:0]    held_q;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [ADDR_W-1:0]    ram_rdata;
	logic [ADDR_W-1:0]    out_value_q;
	logic                 out_last_q;

	// Shared 24 by 24 multiplier; the top by top product falls off mod 2^48.
	always_comb begin
		mul_a = gen_q[HALF_W-1:0];
		mul_b = LCG_MUL_LO;
		if (cmd.mul1) begin
			mul_b = LCG_MUL_HI;
		end
		if (cmd.mul2) begin
			mul_a = gen_q[GEN_W-1:HALF_W];
		end
	end
	assign mul_p    = mul_a * mul_b;
	assign gen_next = acc_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};

	// Generator state and accumulator of the partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= {{SEED_W{1'b0}}, LCG_LOW};
		end else if (seed_we) begin
			gen_q <= {seed, LCG_LOW};
		end else if (cmd.mul2) begin
			gen_q <= gen_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul0) begin
			acc_q <= mul_p + LCG_ADD;
		end else if (cmd.mul1) begin
			acc_q <= gen_next;
		end
	end

	// Remainder unit: restoring steps, two draw bits per cycle.
	assign div = {1'b0, i_q};
	always_comb begin
		t1 = {rem_q, draw_q[DRAW_W-1]};
		r1 = (t1 >= div) ? ADDR_W'(t1 - div) : t1[ADDR_W-1:0];
		t2 = {r1, draw_q[DRAW_W-2]};
		r2 = (t2 >= div) ? ADDR_W'(t2 - div) : t2[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			draw_q    <= {1'b0, gen_next[GEN_W-1:17]};
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			draw_q    <= {draw_q[DRAW_W-3:0], 2'b00};
			rem_q     <= r2;
			mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
		end
	end

	// Count, running index and shuffle index.
	always_ff @(posedge clk) begin
		if (cmd.load_n) begin
			n_q <= (count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count;
		end
		if (cmd.load_n || cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.fill_we || cmd.inc_idx) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.load_i) begin
			i_q <= ADDR_W'(n_q - CNT_W'(1));
		end else if (cmd.wr_pick) begin
			i_q <= i_q - ADDR_W'(1);
		end
		if (cmd.rd_pick) begin
			held_q <= ram_rdata;
		end
	end

	// Store address and data selection.
	always_comb begin
		ram_we    = cmd.fill_we | cmd.wr_i | cmd.wr_pick;
		ram_waddr = idx_q[ADDR_W-1:0];
		ram_wdata = idx_q[ADDR_W-1:0];
		if (cmd.wr_i) begin
			ram_waddr = i_q;
			ram_wdata = ram_rdata;
		end else if (cmd.wr_pick) begin
			ram_waddr = rem_q;
			ram_wdata = held_q;
		end
		ram_re    = cmd.rd_i | cmd.rd_pick | cmd.rd_k;
		ram_raddr = idx_q[ADDR_W-1:0];
		if (cmd.rd_i) begin
			ram_raddr = i_q;
		end else if (cmd.rd_pick) begin
			ram_raddr = rem_q;
		end
	end

	rpg_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_ELEMENTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= ram_rdata;
			out_last_q  <= sts.idx_last;
		end
	end
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	// Status toward the controller.
	assign sts.idx_last = (idx_q == n_q - CNT_W'(1));
	assign sts.i_gt1    = (i_q > ADDR_W'(1));
	assign sts.mod_done = (mod_cnt_q == {MOD_CNT_W{1'b1}});

endmodule

// File: design/rpg_ctrl.sv
// Controller state machine of the random permutation generator: sequences
// fill, draw, remainder, swap and emission. Depends on rpg_pkg.
module rpg_ctrl
	import rpg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CNT_W-1:0] in_count,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cmd_t             cmd,
	input  sts_t             sts
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FILL = 4'd1;
	localparam logic [3:0] S_TEST = 4'd2;
	localparam logic [3:0] S_MUL0 = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_MOD  = 4'd6;
	localparam logic [3:0] S_RDI  = 4'd7;
	localparam logic [3:0] S_RDP  = 4'd8;
	localparam logic [3:0] S_WRI  = 4'd9;
	localparam logic [3:0] S_WRP  = 4'd10;
	localparam logic [3:0] S_ERD  = 4'd11;
	localparam logic [3:0] S_EWT  = 4'd12;
	localparam logic [3:0] S_EOUT = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EOUT);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_count != '0) begin
					cmd.load_n = 1'b1;
					state_d    = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_we = 1'b1;
				if (sts.idx_last) begin
					cmd.load_i = 1'b1;
					state_d    = S_TEST;
				end
			end
			S_TEST: begin
				if (sts.i_gt1) begin
					state_d = S_MUL0;
				end else begin
					cmd.clr_idx = 1'b1;
					state_d     = S_ERD;
				end
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = S_RDI;
				end
			end
			S_RDI: begin
				cmd.rd_i = 1'b1;
				state_d  = S_RDP;
			end
			S_RDP: begin
				cmd.rd_pick = 1'b1;
				state_d     = S_WRI;
			end
			S_WRI: begin
				cmd.wr_i = 1'b1;
				state_d  = S_WRP;
			end
			S_WRP: begin
				cmd.wr_pick = 1'b1;
				state_d     = S_TEST;
			end
			S_ERD: begin
				cmd.rd_k = 1'b1;
				state_d  = S_EWT;
			end
			S_EWT: begin
				cmd.load_out = 1'b1;
				state_d      = S_EOUT;
			end
			S_EOUT: begin
				if (out_ready) begin
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.inc_idx = 1'b1;
						state_d     = S_ERD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/random_permutation_generator.sv
// Random permutation generator: one count in, a shuffled 0..n-1 out, where
// n is the count capped at 64. Each draw runs a three-pass 24-bit multiply
// and then the restoring remainder, two draw bits per step.
// Results leave one at a time, each held until the output side is ready.
// One request at a time; the input is taken only between requests.
// Reset clears the control and loads the generator state from a zero seed.
module random_permutation_generator
	import rpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] element_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] element_value
	output logic        m_tlast,   // last_element
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // seed
);

	cmd_t              cmd;
	sts_t              sts;
	logic [ADDR_W-1:0] out_value;

	// The seed register is always writable.
	assign cfg_ready = 1'b1;

	rpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_count  (s_tdata[CNT_W-1:0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rpg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.count     (s_tdata[CNT_W-1:0]),
		.seed_we   (cfg_valid),
		.seed      (cfg_data),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(8-ADDR_W){1'b0}}, out_value};

endmodule
